// File: design/pcrc_pkg.sv
// shared types, register map and reset constants of the pre-trigger clip record controller
package pcrc_pkg;

  // default pre-capture capacity in entries
  localparam int PRE_DEPTH_DEF = 64;

  // configuration port geometry
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  // register indexes (byte address is 4 times the index)
  localparam logic [2:0] REG_PRECAPTURE  = 3'd0;
  localparam logic [2:0] REG_POSTCAPTURE = 3'd1;
  localparam logic [2:0] REG_GAP_TOL     = 3'd2;
  localparam logic [2:0] REG_ACT_THR     = 3'd3;
  localparam logic [2:0] REG_MAINT_THR   = 3'd4;
  localparam logic [2:0] REG_MAX_LEN     = 3'd5;

  // register reset values
  localparam logic [6:0]  RST_PRECAPTURE  = 7'd16;
  localparam logic [15:0] RST_POSTCAPTURE = 16'd0;
  localparam logic [15:0] RST_GAP_TOL     = 16'd30;
  localparam logic [15:0] RST_ACT_THR     = 16'd0;
  localparam logic [15:0] RST_MAINT_THR   = 16'd0;
  localparam logic [31:0] RST_MAX_LEN     = 32'd60000;

  // result kinds
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_DONE  = 1'b1;

  // cell shift codes
  localparam logic [1:0] SHIFT_NONE = 2'd0;
  localparam logic [1:0] SHIFT_ONE  = 2'd1;
  localparam logic [1:0] SHIFT_TWO  = 2'd2;

  // one pre-capture entry
  typedef struct packed {
    logic [15:0] tag;
    logic [31:0] time_ms;
    logic [31:0] score;
  } entry_t;

  // per-cell control
  typedef struct packed {
    logic [1:0] shift_amt;
    logic       load;
  } cell_ctrl_t;

  // configuration register set
  typedef struct packed {
    logic [6:0]  precapture;
    logic [15:0] postcapture;
    logic [15:0] gap_tol;
    logic [15:0] act_thr;
    logic [15:0] maint_thr;
    logic [31:0] max_len;
  } cfg_t;

endpackage

// File: design/pcrc_cell.sv
// one pre-capture queue cell: holds an entry and shifts toward the queue head
module pcrc_cell (
  input  logic                 clk,
  input  pcrc_pkg::cell_ctrl_t ctrl,
  input  pcrc_pkg::entry_t     new_entry,
  input  pcrc_pkg::entry_t     nbr1,
  input  pcrc_pkg::entry_t     nbr2,
  output pcrc_pkg::entry_t     q
);

  pcrc_pkg::entry_t q_r;
  pcrc_pkg::entry_t q_nxt;

  // take from a neighbor on shift, or load the incoming beat
  always_comb begin
    case (ctrl.shift_amt)
      pcrc_pkg::SHIFT_ONE: q_nxt = nbr1;
      pcrc_pkg::SHIFT_TWO: q_nxt = nbr2;
      default:             q_nxt = q_r;
    endcase
    if (ctrl.load) begin
      q_nxt = new_entry;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign q = q_r;

endmodule

// File: design/pcrc_cfg.sv
// apb-style configuration register file
module pcrc_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pcrc_pkg::ADDR_W-1:0] paddr,
  input  logic [pcrc_pkg::DATA_W-1:0] pwdata,
  output logic [pcrc_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  output pcrc_pkg::cfg_t              cfg
);

  pcrc_pkg::cfg_t cfg_r;
  logic [2:0]     reg_idx;
  logic           wr_en;

  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.precapture  <= pcrc_pkg::RST_PRECAPTURE;
      cfg_r.postcapture <= pcrc_pkg::RST_POSTCAPTURE;
      cfg_r.gap_tol     <= pcrc_pkg::RST_GAP_TOL;
      cfg_r.act_thr     <= pcrc_pkg::RST_ACT_THR;
      cfg_r.maint_thr   <= pcrc_pkg::RST_MAINT_THR;
      cfg_r.max_len     <= pcrc_pkg::RST_MAX_LEN;
    end else if (wr_en) begin
      case (reg_idx)
        pcrc_pkg::REG_PRECAPTURE:  cfg_r.precapture  <= pwdata[6:0];
        pcrc_pkg::REG_POSTCAPTURE: cfg_r.postcapture <= pwdata[15:0];
        pcrc_pkg::REG_GAP_TOL:     cfg_r.gap_tol     <= pwdata[15:0];
        pcrc_pkg::REG_ACT_THR:     cfg_r.act_thr     <= pwdata[15:0];
        pcrc_pkg::REG_MAINT_THR:   cfg_r.maint_thr   <= pwdata[15:0];
        pcrc_pkg::REG_MAX_LEN:     cfg_r.max_len     <= pwdata;
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    case (reg_idx)
      pcrc_pkg::REG_PRECAPTURE:  prdata = {25'd0, cfg_r.precapture};
      pcrc_pkg::REG_POSTCAPTURE: prdata = {16'd0, cfg_r.postcapture};
      pcrc_pkg::REG_GAP_TOL:     prdata = {16'd0, cfg_r.gap_tol};
      pcrc_pkg::REG_ACT_THR:     prdata = {16'd0, cfg_r.act_thr};
      pcrc_pkg::REG_MAINT_THR:   prdata = {16'd0, cfg_r.maint_thr};
      pcrc_pkg::REG_MAX_LEN:     prdata = cfg_r.max_len;
      default:                   prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

// File: design/pretrigger_clip_record_controller_top.sv
// top level: pre-capture queue of cells, clip record control and result register
//
// Every frame beat is pushed into a pre-capture queue built as a row of PRE_DEPTH cells, the
// oldest frame in cell 0; cells shift toward the head by zero, one or two places per cycle
// (one dropped frame plus one written frame). An accepted beat's result, if any, appears
// in the output register on the next cycle, so the block sustains one beat per clock while
// the result side keeps up and no trim is pending; in_ready follows out_ready when a result
// is waiting. After the pre-capture depth register is lowered below the current fill, the
// queue trims itself one entry per cycle with in_ready low, so the first beat after such a
// write waits until the trim is done. Configuration is read and written through an APB-style
// port with registers at byte addresses 0, 4, 8, 12, 16 and 20.
module pretrigger_clip_record_controller_top #(
  parameter int PRE_DEPTH = pcrc_pkg::PRE_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pcrc_pkg::ADDR_W-1:0] paddr,
  input  logic [pcrc_pkg::DATA_W-1:0] pwdata,
  output logic [pcrc_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  // frame beats
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [15:0]                 in_frame_tag,
  input  logic [31:0]                 in_capture_time_ms,
  input  logic [31:0]                 in_now_ms,
  input  logic [15:0]                 in_change_rate,
  input  logic                        in_interesting,
  input  logic [31:0]                 in_frame_score,
  input  logic                        in_exit_request,
  // results
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_kind,
  output logic [15:0]                 out_out_tag,
  output logic [23:0]                 out_clip_frames,
  output logic [15:0]                 out_best_tag,
  output logic [15:0]                 out_trim_frames,
  output logic                        out_stop_by_length,
  output logic                        out_stop_by_gap
);

  localparam int CW = $clog2(PRE_DEPTH + 1);
  localparam int XW = (CW > 7) ? CW : 7;

  pcrc_pkg::cfg_t cfg;

  // configuration registers
  pcrc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // control state
  logic [CW-1:0] count_r, count_nxt;
  logic          rec_r, rec_nxt;
  logic [15:0]   gap_r, gap_nxt;
  logic [23:0]   written_r, written_nxt;
  logic [31:0]   clip_start_r, clip_start_nxt;
  logic          best_none_r, best_none_nxt;
  logic [31:0]   best_val_r, best_val_nxt;
  logic [15:0]   best_frame_r, best_frame_nxt;

  // result register
  logic        out_valid_r;
  logic        out_kind_r;
  logic [15:0] out_tag_r;
  logic [23:0] out_clip_r;
  logic [15:0] out_best_r;
  logic [15:0] out_trim_r;
  logic        out_len_r;
  logic        out_gap_r;

  // queue cells, two spare neighbor slots past the tail
  pcrc_pkg::entry_t     cell_q [PRE_DEPTH+2];
  pcrc_pkg::cell_ctrl_t cell_ctrl [PRE_DEPTH];
  pcrc_pkg::entry_t     new_e;
  pcrc_pkg::entry_t     head;

  logic [XW-1:0] pre_x;
  logic [CW-1:0] eff_depth;
  logic          trim_need;
  logic          acc;
  logic          drop1;
  logic [CW-1:0] c1;
  logic          start;
  logic          active;
  logic [31:0]   clip_eff;
  logic [15:0]   gap_eff;
  logic [23:0]   written_eff;
  logic          best_none_eff;
  logic [31:0]   age;
  logic          len_stop;
  logic          gap_stop;
  logic          stop;
  logic          pop;
  logic [15:0]   gap_inc;
  logic          better;
  logic [1:0]    shift_amt;
  logic          wr_en;
  logic [CW-1:0] wr_pos;
  logic [17:0]   trim_s;
  logic [15:0]   trim_val;

  // effective depth, clamped to 1..PRE_DEPTH
  always_comb begin
    pre_x = XW'(cfg.precapture);
    if (pre_x == '0) begin
      eff_depth = CW'(1);
    end else if (pre_x > XW'(PRE_DEPTH)) begin
      eff_depth = CW'(PRE_DEPTH);
    end else begin
      eff_depth = pre_x[CW-1:0];
    end
  end

  // handshake
  assign trim_need = count_r > eff_depth;
  assign in_ready  = !trim_need && (!out_valid_r || out_ready);
  assign acc       = in_valid && in_ready;

  // push side: drop the oldest entry when full, find the head after the push
  assign new_e.tag     = in_frame_tag;
  assign new_e.time_ms = in_capture_time_ms;
  assign new_e.score   = in_frame_score;
  assign drop1         = count_r >= eff_depth;
  assign c1            = count_r - CW'(drop1);

  always_comb begin
    if (c1 == '0) begin
      head = new_e;
    end else if (drop1) begin
      head = cell_q[1];
    end else begin
      head = cell_q[0];
    end
  end

  // trigger and stop decisions
  assign start         = !rec_r && in_interesting && (in_change_rate >= cfg.act_thr);
  assign active        = rec_r || start;
  assign clip_eff      = start ? head.time_ms : clip_start_r;
  assign gap_eff       = start ? 16'd0 : gap_r;
  assign written_eff   = start ? 24'd0 : written_r;
  assign best_none_eff = start || best_none_r;
  assign age           = in_now_ms - clip_eff;
  assign len_stop      = (age >= cfg.max_len) || in_exit_request;
  assign gap_stop      = gap_eff >= cfg.gap_tol;
  assign stop          = active && (len_stop || gap_stop);
  assign pop           = active && !stop;
  assign gap_inc       = (gap_eff == 16'hFFFF) ? gap_eff : gap_eff + 16'd1;
  assign better        = best_none_eff || (head.score > best_val_r);

  // trim length from raw register values, clamped at zero
  assign trim_s   = {2'b00, cfg.gap_tol} - {2'b00, cfg.postcapture} - {11'd0, cfg.precapture};
  assign trim_val = trim_s[17] ? 16'd0 : trim_s[15:0];

  // queue movement
  always_comb begin
    shift_amt = pcrc_pkg::SHIFT_NONE;
    wr_en     = 1'b0;
    wr_pos    = c1 - CW'(pop);
    if (acc) begin
      if (drop1 && pop) begin
        shift_amt = pcrc_pkg::SHIFT_TWO;
      end else if (drop1 || pop) begin
        shift_amt = pcrc_pkg::SHIFT_ONE;
      end
      wr_en = !(pop && (c1 == '0));
    end else if (trim_need) begin
      shift_amt = pcrc_pkg::SHIFT_ONE;
    end
  end

  // cell row
  assign cell_q[PRE_DEPTH]   = '0;
  assign cell_q[PRE_DEPTH+1] = '0;

  for (genvar i = 0; i < PRE_DEPTH; i++) begin : g_cell
    assign cell_ctrl[i].shift_amt = shift_amt;
    assign cell_ctrl[i].load      = wr_en && (wr_pos == CW'(i));

    pcrc_cell u_cell (
      .clk       (clk),
      .ctrl      (cell_ctrl[i]),
      .new_entry (new_e),
      .nbr1      (cell_q[i+1]),
      .nbr2      (cell_q[i+2]),
      .q         (cell_q[i])
    );
  end

  // next control state
  always_comb begin
    count_nxt      = count_r;
    rec_nxt        = rec_r;
    gap_nxt        = gap_r;
    written_nxt    = written_r;
    clip_start_nxt = clip_start_r;
    best_none_nxt  = best_none_r;
    best_val_nxt   = best_val_r;
    best_frame_nxt = best_frame_r;
    if (acc) begin
      count_nxt = c1 + CW'(1) - CW'(pop);
      if (active) begin
        rec_nxt        = !stop;
        clip_start_nxt = clip_eff;
        best_none_nxt  = best_none_eff;
        written_nxt    = written_eff;
        gap_nxt        = gap_inc;
        if (pop) begin
          if (written_eff != 24'hFFFFFF) begin
            written_nxt = written_eff + 24'd1;
          end
          if (in_interesting && (in_change_rate > cfg.maint_thr)) begin
            gap_nxt = 16'd0;
          end
          if (better) begin
            best_none_nxt  = 1'b0;
            best_val_nxt   = head.score;
            best_frame_nxt = head.tag;
          end
        end
      end
    end else if (trim_need) begin
      count_nxt = count_r - CW'(1);
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      rec_r        <= 1'b0;
      gap_r        <= '0;
      written_r    <= '0;
      clip_start_r <= '0;
      best_none_r  <= 1'b1;
      best_val_r   <= '0;
      best_frame_r <= '0;
    end else begin
      count_r      <= count_nxt;
      rec_r        <= rec_nxt;
      gap_r        <= gap_nxt;
      written_r    <= written_nxt;
      clip_start_r <= clip_start_nxt;
      best_none_r  <= best_none_nxt;
      best_val_r   <= best_val_nxt;
      best_frame_r <= best_frame_nxt;
    end
  end

  // result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (acc) begin
      out_valid_r <= active;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (acc) begin
      out_kind_r <= stop ? pcrc_pkg::KIND_DONE : pcrc_pkg::KIND_WRITE;
      out_tag_r  <= stop ? 16'd0 : head.tag;
      out_clip_r <= stop ? written_eff : 24'd0;
      out_best_r <= stop ? best_frame_r : 16'd0;
      out_trim_r <= stop ? trim_val : 16'd0;
      out_len_r  <= stop && len_stop;
      out_gap_r  <= stop && gap_stop;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_kind           = out_kind_r;
  assign out_out_tag        = out_tag_r;
  assign out_clip_frames    = out_clip_r;
  assign out_best_tag       = out_best_r;
  assign out_trim_frames    = out_trim_r;
  assign out_stop_by_length = out_len_r;
  assign out_stop_by_gap    = out_gap_r;

  // checks
  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(PRE_DEPTH))
    else $error("queue fill beyond capacity");

  a_fill_within_depth : assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> count_r <= $past(eff_depth))
    else $error("fill beyond depth after a beat");

  a_write_no_grow : assert property (@(posedge clk) disable iff (!rst_n)
    (acc && pop) |=> count_r <= $past(count_r))
    else $error("queue grew on a write beat");

  a_stop_ends_clip : assert property (@(posedge clk) disable iff (!rst_n)
    (acc && stop) |=> !rec_r)
    else $error("recording still active after a stop");

  a_recording_gives_result : assert property (@(posedge clk) disable iff (!rst_n)
    (acc && rec_r) |=> out_valid_r)
    else $error("no result for a beat while recording");

endmodule
